[design/fik_pkg.sv]
package fik_pkg;

   // One photon direction with the indices on both sides of the interface.
   typedef struct packed {
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic [14:0]        index_from;
      logic [14:0]        index_to;
      logic [31:0]        rand_u;
   } req_type;

   // Outgoing direction and the kind of event that produced it.
   typedef struct packed {
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      logic signed [31:0] new_z;
      logic [1:0]         outcome;
   } rsp_type;

   localparam logic [1:0] OUTCOME_PASS    = 2'd0;
   localparam logic [1:0] OUTCOME_REFRACT = 2'd1;
   localparam logic [1:0] OUTCOME_REFLECT = 2'd2;
   localparam logic [1:0] OUTCOME_TIR     = 2'd3;

   localparam logic [61:0] ONE_Q60  = 62'd1 << 60;
   localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
   localparam logic [30:0] NEAR_ONE = 31'h3FFF_FFFF;
   localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;

   // Radicand width of the square roots and the common divider format.
   localparam int SQRT_RAD_W = 62;
   localparam int DIV_NUM_W  = 64;
   localparam int DIV_DEN_W  = 32;
   localparam int DIV_QUO_W  = 33;

   // Everything an item carries down the pipeline; fields are filled in as
   // the item reaches the stage that computes them.
   typedef struct packed {
      req_type     req;
      logic [31:0] mag_x;
      logic [31:0] mag_y;
      logic [14:0] idx_diff;
      logic [15:0] idx_sum;
      logic [30:0] c0;
      logic [30:0] s0;
      logic [30:0] s1;
      logic [30:0] c1;
      logic        equal;
      logic        normal;
      logic        tir;
      logic        zero_den;
      logic        ovf_x;
      logic        ovf_y;
      logic [32:0] q_x;
      logic [32:0] q_y;
      logic [32:0] r_norm;
   } ctx_type;

   localparam int CTX_W = $bits(ctx_type);

   // Product of two Q0.32 values that are each at most one.
   function automatic logic [32:0] mul_q32(input logic [32:0] a, input logic [32:0] b);
      logic [63:0] prod;
      prod = 64'(a[31:0]) * 64'(b[31:0]);
      if (a[32]) begin
         mul_q32 = b;
      end else if (b[32]) begin
         mul_q32 = a;
      end else begin
         mul_q32 = 33'(prod >> 32);
      end
   endfunction

endpackage

[design/fresnel_interface_kernel_unit.sv]
// Fresnel interface kernel. A photon direction (signed Q2.30) meets a planar
// interface normal to z between indices index_from and index_to (Q2.13).
// The unit takes one item in every clock cycle: busy never rises, so start
// may be held high for as long as items are available. Each item produces
// exactly one result, shown on rsp_data for a single cycle with rsp_strobe
// high, in order of arrival. The receiver cannot hold results off and must
// take each one as it appears. The pipeline runs through the two 31-stage
// square roots and the two 33-stage dividers, each deciding one result bit
// per stage, plus the multiplier and adder stages between them. The Fresnel
// enable register is written through the csr_ port, which is always ready;
// it should only be changed while no item is in flight.
module fresnel_interface_kernel_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fik_pkg::req_type req_data,
   output logic             rsp_strobe,
   output fik_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);
   import fik_pkg::*;

   logic enable_ff;
   logic accept;

   // Stage registers in pipeline order.
   logic        v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, v10_ff;
   ctx_type     ctx1_in, ctx1_ff, ctx2_ff, ctx3_in, ctx3_ff, ctx4_in, ctx4_ff;
   ctx_type     ctx5_in, ctx5_ff, ctx6_ff, ctx7_in, ctx7_ff, ctx8_ff, ctx9_ff, ctx10_ff;
   ctx_type     diva_ctx, divb_ctx;
   logic [61:0] c0sq_ff, s1sq_ff;
   logic [45:0] num_s_ff;
   logic [29:0] dsq_ff;
   logic [31:0] ssq_ff;
   logic [46:0] px_ff, py_ff;
   logic [61:0] pcc_ff, pss_ff, psc_ff, pcs_ff;
   logic [31:0] cs_ff, cd_ff, ss_ff, sd_ff;
   logic [32:0] a_ff, b_ff, sa_ff, sb_ff, sa9_ff, sab_ff;
   logic        refl_ff;
   logic [30:0] s1_sel;
   logic [33:0] r_sum;
   logic [32:0] r_fin;
   rsp_type     rsp_in, rsp_ff;
   logic        rsp_strobe_ff;

   // Unit hook-ups.
   logic                            sq0_valid, sq1_valid, diva_valid, divb_valid;
   logic [SQRT_RAD_W/2-1:0]         sq0_root, sq1_root;
   logic [CTX_W-1:0]                sq0_tag, sq1_tag, diva_tag, divb_tag;
   logic [3:0][DIV_NUM_W-1:0]       diva_num;
   logic [3:0][DIV_DEN_W-1:0]       diva_den;
   logic [3:0][DIV_QUO_W-1:0]       diva_quo;
   logic [1:0][DIV_NUM_W-1:0]       divb_num;
   logic [1:0][DIV_DEN_W-1:0]       divb_den;
   logic [1:0][DIV_QUO_W-1:0]       divb_quo;

   // The receiver never stalls, so neither does the pipeline.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         enable_ff <= csr_data;
      end
   end

   // Stage 1: magnitudes, the incidence cosine clamped to one, index sum and difference.
   always_comb begin
      logic [31:0] mag_z;
      ctx1_in       = '0;
      ctx1_in.req   = req_data;
      ctx1_in.mag_x = req_data.dir_x[31] ? 32'(-req_data.dir_x) : 32'(req_data.dir_x);
      ctx1_in.mag_y = req_data.dir_y[31] ? 32'(-req_data.dir_y) : 32'(req_data.dir_y);
      mag_z         = req_data.dir_z[31] ? 32'(-req_data.dir_z) : 32'(req_data.dir_z);
      ctx1_in.c0    = (mag_z > 32'(ONE_Q30)) ? ONE_Q30 : mag_z[30:0];
      ctx1_in.idx_diff = (req_data.index_to >= req_data.index_from) ?
                         req_data.index_to - req_data.index_from :
                         req_data.index_from - req_data.index_to;
      ctx1_in.idx_sum  = 16'(req_data.index_to) + 16'(req_data.index_from);
      ctx1_in.equal    = req_data.index_to == req_data.index_from;
   end

   // Stage 2 squares the cosine; the first square root then gives the sine.
   fik_sqrt_pipe #(.RAD_W(SQRT_RAD_W), .TAG_W(CTX_W)) u_sqrt_sin0 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_rad    (ONE_Q60 - c0sq_ff),
      .in_tag    (ctx2_ff),
      .out_valid (sq0_valid),
      .out_root  (sq0_root),
      .out_tag   (sq0_tag)
   );

   // Stage 3: every product that the first divider needs.
   always_comb begin
      ctx3_in    = ctx_type'(sq0_tag);
      ctx3_in.s0 = sq0_root;
   end

   // The first divider handles the refracted sine, the normal-incidence
   // reflectance and the two scaled tangential components side by side.
   always_comb begin
      diva_ctx        = ctx3_ff;
      diva_ctx.tir    = 46'(num_s_ff) > {1'b0, ctx3_ff.req.index_to, 30'd0};
      diva_ctx.normal = ctx3_ff.c0 > NEAR_ONE;
      diva_ctx.ovf_x  = {1'b0, px_ff[46:33]} >= ctx3_ff.req.index_to;
      diva_ctx.ovf_y  = {1'b0, py_ff[46:33]} >= ctx3_ff.req.index_to;
      diva_num[0]     = 64'(num_s_ff);
      diva_den[0]     = 32'(ctx3_ff.req.index_to);
      diva_num[1]     = {2'b00, dsq_ff, 32'd0};
      diva_den[1]     = ssq_ff;
      diva_num[2]     = 64'(px_ff);
      diva_den[2]     = 32'(ctx3_ff.req.index_to);
      diva_num[3]     = 64'(py_ff);
      diva_den[3]     = 32'(ctx3_ff.req.index_to);
   end

   fik_div_pipe #(
      .LANES (4),
      .NUM_W (DIV_NUM_W),
      .DEN_W (DIV_DEN_W),
      .QUO_W (DIV_QUO_W),
      .TAG_W (CTX_W)
   ) u_div_index (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_num    (diva_num),
      .in_den    (diva_den),
      .in_tag    (diva_ctx),
      .out_valid (diva_valid),
      .out_quo   (diva_quo),
      .out_tag   (diva_tag)
   );

   // Stage 4: with a zero target index only normal incidence survives, and
   // the refracted sine is then taken as zero.
   always_comb begin
      ctx4_in        = ctx_type'(diva_tag);
      s1_sel         = (ctx4_in.req.index_to == '0) ? '0 : diva_quo[0][30:0];
      ctx4_in.s1     = s1_sel;
      ctx4_in.r_norm = diva_quo[1];
      ctx4_in.q_x    = diva_quo[2];
      ctx4_in.q_y    = diva_quo[3];
   end

   fik_sqrt_pipe #(.RAD_W(SQRT_RAD_W), .TAG_W(CTX_W)) u_sqrt_cos1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_rad    (ONE_Q60 - s1sq_ff),
      .in_tag    (ctx4_ff),
      .out_valid (sq1_valid),
      .out_root  (sq1_root),
      .out_tag   (sq1_tag)
   );

   always_comb begin
      ctx5_in    = ctx_type'(sq1_tag);
      ctx5_in.c1 = sq1_root;
   end

   // The second divider forms the sine ratio and the cosine ratio of the
   // general Fresnel formula.
   always_comb begin
      divb_ctx          = ctx6_ff;
      divb_ctx.zero_den = (ss_ff == '0) || (cd_ff == '0);
      divb_num[0]       = {sd_ff, 32'd0};
      divb_den[0]       = ss_ff;
      divb_num[1]       = {cs_ff, 32'd0};
      divb_den[1]       = cd_ff;
   end

   fik_div_pipe #(
      .LANES (2),
      .NUM_W (DIV_NUM_W),
      .DEN_W (DIV_DEN_W),
      .QUO_W (DIV_QUO_W),
      .TAG_W (CTX_W)
   ) u_div_ratio (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v6_ff),
      .in_num    (divb_num),
      .in_den    (divb_den),
      .in_tag    (divb_ctx),
      .out_valid (divb_valid),
      .out_quo   (divb_quo),
      .out_tag   (divb_tag)
   );

   assign ctx7_in = ctx_type'(divb_tag);

   // Stage 10: reflectance, either the normal-incidence value, one when a
   // denominator is zero, or half of A + A*B, and the draw against the random word.
   always_comb begin
      r_sum = 34'(sa9_ff) + 34'(sab_ff);
      if (ctx9_ff.normal) begin
         r_fin = ctx9_ff.r_norm;
      end else if (ctx9_ff.zero_den) begin
         r_fin = ONE_Q32;
      end else begin
         r_fin = 33'(r_sum >> 1);
      end
   end

   // Output stage: pick the event and form the outgoing direction.
   always_comb begin
      logic signed [31:0] neg_z;
      logic signed [31:0] scl_x;
      logic signed [31:0] scl_y;
      logic signed [31:0] ref_z;
      neg_z = (ctx10_ff.req.dir_z == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -ctx10_ff.req.dir_z;
      if (ctx10_ff.req.dir_x[31]) begin
         scl_x = (ctx10_ff.ovf_x || ctx10_ff.q_x >= 33'h0_8000_0000) ?
                 32'sh8000_0000 : -$signed(ctx10_ff.q_x[31:0]);
      end else begin
         scl_x = (ctx10_ff.ovf_x || ctx10_ff.q_x > 33'h0_7FFF_FFFF) ?
                 32'sh7FFF_FFFF : $signed(ctx10_ff.q_x[31:0]);
      end
      if (ctx10_ff.req.dir_y[31]) begin
         scl_y = (ctx10_ff.ovf_y || ctx10_ff.q_y >= 33'h0_8000_0000) ?
                 32'sh8000_0000 : -$signed(ctx10_ff.q_y[31:0]);
      end else begin
         scl_y = (ctx10_ff.ovf_y || ctx10_ff.q_y > 33'h0_7FFF_FFFF) ?
                 32'sh7FFF_FFFF : $signed(ctx10_ff.q_y[31:0]);
      end
      if (ctx10_ff.req.dir_z > 0) begin
         ref_z = $signed(32'(ctx10_ff.c1));
      end else if (ctx10_ff.req.dir_z < 0) begin
         ref_z = -$signed(32'(ctx10_ff.c1));
      end else begin
         ref_z = '0;
      end

      rsp_in.new_x   = ctx10_ff.req.dir_x;
      rsp_in.new_y   = ctx10_ff.req.dir_y;
      rsp_in.new_z   = ctx10_ff.req.dir_z;
      rsp_in.outcome = OUTCOME_PASS;
      if (ctx10_ff.equal) begin
         rsp_in.outcome = OUTCOME_PASS;
      end else if (ctx10_ff.tir) begin
         rsp_in.new_z   = neg_z;
         rsp_in.outcome = OUTCOME_TIR;
      end else if (refl_ff) begin
         rsp_in.new_z   = neg_z;
         rsp_in.outcome = OUTCOME_REFLECT;
      end else begin
         rsp_in.outcome = OUTCOME_REFRACT;
         if (!ctx10_ff.normal) begin
            rsp_in.new_x = scl_x;
            rsp_in.new_y = scl_y;
            rsp_in.new_z = ref_z;
         end
      end
   end

   // Valid bits travel with the items; they are the only control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         v5_ff         <= 1'b0;
         v6_ff         <= 1'b0;
         v7_ff         <= 1'b0;
         v8_ff         <= 1'b0;
         v9_ff         <= 1'b0;
         v10_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         v1_ff         <= accept;
         v2_ff         <= v1_ff;
         v3_ff         <= sq0_valid;
         v4_ff         <= diva_valid;
         v5_ff         <= sq1_valid;
         v6_ff         <= v5_ff;
         v7_ff         <= divb_valid;
         v8_ff         <= v7_ff;
         v9_ff         <= v8_ff;
         v10_ff        <= v9_ff;
         rsp_strobe_ff <= v10_ff;
      end
   end

   // Payload registers, one multiplier or one wide add on each path.
   always_ff @(posedge clock) begin
      ctx1_ff  <= ctx1_in;
      ctx2_ff  <= ctx1_ff;
      c0sq_ff  <= 62'(ctx1_ff.c0) * 62'(ctx1_ff.c0);

      ctx3_ff  <= ctx3_in;
      num_s_ff <= 46'(ctx3_in.req.index_from) * 46'(ctx3_in.s0);
      dsq_ff   <= 30'(ctx3_in.idx_diff) * 30'(ctx3_in.idx_diff);
      ssq_ff   <= 32'(ctx3_in.idx_sum) * 32'(ctx3_in.idx_sum);
      px_ff    <= 47'(ctx3_in.mag_x) * 47'(ctx3_in.req.index_from);
      py_ff    <= 47'(ctx3_in.mag_y) * 47'(ctx3_in.req.index_from);

      ctx4_ff  <= ctx4_in;
      s1sq_ff  <= 62'(s1_sel) * 62'(s1_sel);

      ctx5_ff  <= ctx5_in;
      pcc_ff   <= 62'(ctx5_in.c0) * 62'(ctx5_in.c1);
      pss_ff   <= 62'(ctx5_in.s0) * 62'(ctx5_in.s1);
      psc_ff   <= 62'(ctx5_in.s0) * 62'(ctx5_in.c1);
      pcs_ff   <= 62'(ctx5_in.c0) * 62'(ctx5_in.s1);

      // Angle sum and difference terms, floored back to Q0.30.
      ctx6_ff  <= ctx5_ff;
      cs_ff    <= 32'(((pcc_ff >= pss_ff) ? pcc_ff - pss_ff : pss_ff - pcc_ff) >> 30);
      cd_ff    <= 32'((63'(pcc_ff) + 63'(pss_ff)) >> 30);
      ss_ff    <= 32'((63'(psc_ff) + 63'(pcs_ff)) >> 30);
      sd_ff    <= 32'(((psc_ff >= pcs_ff) ? psc_ff - pcs_ff : pcs_ff - psc_ff) >> 30);

      // Ratios saturate at one before they are squared.
      ctx7_ff  <= ctx7_in;
      a_ff     <= (divb_quo[0] > ONE_Q32) ? ONE_Q32 : divb_quo[0];
      b_ff     <= (divb_quo[1] > ONE_Q32) ? ONE_Q32 : divb_quo[1];

      ctx8_ff  <= ctx7_ff;
      sa_ff    <= mul_q32(a_ff, a_ff);
      sb_ff    <= mul_q32(b_ff, b_ff);

      ctx9_ff  <= ctx8_ff;
      sa9_ff   <= sa_ff;
      sab_ff   <= mul_q32(sa_ff, sb_ff);

      ctx10_ff <= ctx9_ff;
      refl_ff  <= enable_ff && ({1'b0, ctx9_ff.req.rand_u} <= r_fin);

      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;
endmodule

[design/fik_sqrt_pipe.sv]
module fik_sqrt_pipe #(
   parameter int RAD_W = 62,
   parameter int TAG_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [RAD_W-1:0]     in_rad,
   input  logic [TAG_W-1:0]     in_tag,
   output logic                 out_valid,
   output logic [RAD_W/2-1:0]   out_root,
   output logic [TAG_W-1:0]     out_tag
);
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;

   logic              vld_ff  [ROOT_W+1];
   logic [TAG_W-1:0]  tag_ff  [ROOT_W+1];
   logic [ROOT_W-1:0] root_ff [ROOT_W+1];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      tag_ff[0]  <= in_tag;
      root_ff[0] <= '0;
      rem_ff[0]  <= '0;
      rad_ff[0]  <= in_rad;
   end

   // Each stage brings down two radicand bits and decides one root bit.
   for (genvar k = 1; k <= ROOT_W; k++) begin : g_stage
      logic [REM_W+1:0] cur;
      logic [REM_W+1:0] trial;
      logic             ge;

      assign cur   = {rem_ff[k-1], rad_ff[k-1][RAD_W-2*k+1 -: 2]};
      assign trial = (REM_W+2)'({root_ff[k-1], 2'b01});
      assign ge    = cur >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_ff[k-1];
         end
         tag_ff[k]  <= tag_ff[k-1];
         root_ff[k] <= {root_ff[k-1][ROOT_W-2:0], ge};
      end

      if (k < ROOT_W) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[k] <= REM_W'(ge ? cur - trial : cur);
            rad_ff[k] <= rad_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_tag   = tag_ff[ROOT_W];
endmodule

[design/fik_div_pipe.sv]
module fik_div_pipe #(
   parameter int LANES = 1,
   parameter int NUM_W = 64,
   parameter int DEN_W = 32,
   parameter int QUO_W = 33,
   parameter int TAG_W = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [LANES-1:0][NUM_W-1:0] in_num,
   input  logic [LANES-1:0][DEN_W-1:0] in_den,
   input  logic [TAG_W-1:0]            in_tag,
   output logic                        out_valid,
   output logic [LANES-1:0][QUO_W-1:0] out_quo,
   output logic [TAG_W-1:0]            out_tag
);
   logic                        vld_ff [QUO_W+1];
   logic [TAG_W-1:0]            tag_ff [QUO_W+1];
   logic [LANES-1:0][QUO_W-1:0] quo_ff [QUO_W+1];
   logic [LANES-1:0][DEN_W-1:0] rem_ff [QUO_W];
   logic [LANES-1:0][DEN_W-1:0] den_ff [QUO_W];
   logic [LANES-1:0][QUO_W-1:0] low_ff [QUO_W];

   // The bits above the quotient field form the starting remainder; they
   // are below the divisor whenever the quotient fits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      tag_ff[0] <= in_tag;
      quo_ff[0] <= '0;
      for (int l = 0; l < LANES; l++) begin
         rem_ff[0][l] <= DEN_W'(in_num[l] >> QUO_W);
         low_ff[0][l] <= in_num[l][QUO_W-1:0];
         den_ff[0][l] <= in_den[l];
      end
   end

   // Restoring division, one quotient bit per stage.
   for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
      logic [LANES-1:0][DEN_W:0] trial;
      logic [LANES-1:0][DEN_W:0] diff;
      logic [LANES-1:0]          ge;

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         assign trial[l] = {rem_ff[k-1][l], low_ff[k-1][l][QUO_W-k]};
         assign diff[l]  = trial[l] - {1'b0, den_ff[k-1][l]};
         assign ge[l]    = trial[l] >= {1'b0, den_ff[k-1][l]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_ff[k-1];
         end
         tag_ff[k] <= tag_ff[k-1];
         for (int l = 0; l < LANES; l++) begin
            quo_ff[k][l] <= {quo_ff[k-1][l][QUO_W-2:0], ge[l]};
         end
      end

      if (k < QUO_W) begin : g_carry
         always_ff @(posedge clock) begin
            for (int l = 0; l < LANES; l++) begin
               rem_ff[k][l] <= DEN_W'(ge[l] ? diff[l] : trial[l]);
               low_ff[k][l] <= low_ff[k-1][l];
               den_ff[k][l] <= den_ff[k-1][l];
            end
         end
      end
   end

   assign out_valid = vld_ff[QUO_W];
   assign out_quo   = quo_ff[QUO_W];
   assign out_tag   = tag_ff[QUO_W];
endmodule

[tb/sv/tb.sv]
module tb;
   import fik_pkg::*;

   // Clock, reset and the ports of the unit.
   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_data;

   // The testbench keeps its own copy of the Fresnel enable register.
   bit      enable_copy;
   rsp_type pending_dirs[$];
   int      items_taken;
   int      csr_writes;
   int      mismatches;
   bit      gaps_on;

   fresnel_interface_kernel_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Integer square root by the usual bit-pair method, floored.
   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned gap(input longint unsigned a, input longint unsigned b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // A quotient in Q0.32, saturated at one.
   function automatic longint unsigned frac_q32(input longint unsigned num,
                                                input longint unsigned den);
      longint unsigned q;
      q = (num << 32) / den;
      return (q > 64'h1_0000_0000) ? 64'h1_0000_0000 : q;
   endfunction

   function automatic longint unsigned prod_q32(input longint unsigned a,
                                                input longint unsigned b);
      if (a >= 64'h1_0000_0000) return b;
      if (b >= 64'h1_0000_0000) return a;
      return (a * b) >> 32;
   endfunction

   function automatic logic signed [31:0] clamp32(input longint signed v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // Scales a transverse component by n0/n1, truncating towards zero.
   function automatic longint signed bend(input longint signed v, input longint unsigned n0,
                                          input longint unsigned n1);
      longint unsigned mag;
      longint unsigned m;
      if (n1 == 0) return v;
      mag = (v < 0) ? longint'(-v) : longint'(v);
      m = mag * n0 / n1;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   // Unpolarised reflectance from the sum and difference angle formulae.
   function automatic longint unsigned oblique_reflectance(input longint unsigned c0,
      input longint unsigned s0, input longint unsigned c1, input longint unsigned s1);
      longint unsigned cs, cd, ss, sd, a, b, sa, sb;
      cs = gap(c0 * c1, s0 * s1) >> 30;
      cd = (c0 * c1 + s0 * s1) >> 30;
      ss = (s0 * c1 + c0 * s1) >> 30;
      sd = gap(s0 * c1, c0 * s1) >> 30;
      if (ss == 0 || cd == 0) return 64'h1_0000_0000;
      a = frac_q32(sd, ss);
      b = frac_q32(cs, cd);
      sa = prod_q32(a, a);
      sb = prod_q32(b, b);
      return (sa + prod_q32(sa, sb)) >> 1;
   endfunction

   // Works out the outgoing direction and outcome of one photon.
   function automatic rsp_type scatter_photon(input req_type r, input bit en);
      longint signed   dx, dy, dz, nx, ny, nz;
      longint unsigned n0, n1, u, c0, s0, num, s1, c1, refl_prob, d, s;
      bit              normal, refl;
      logic [1:0]      oc;
      rsp_type         o;
      dx = longint'(r.dir_x);
      dy = longint'(r.dir_y);
      dz = longint'(r.dir_z);
      n0 = r.index_from;
      n1 = r.index_to;
      u  = r.rand_u;
      nx = dx;
      ny = dy;
      nz = dz;
      oc = OUTCOME_PASS;
      if (n0 != n1) begin
         c0 = (dz < 0) ? longint'(-dz) : longint'(dz);
         if (c0 > 64'd1 << 30) c0 = 64'd1 << 30;
         s0 = root_floor((64'd1 << 60) - c0 * c0);
         num = n0 * s0;
         if (num > (n1 << 30)) begin
            nz = -dz;
            oc = OUTCOME_TIR;
         end else begin
            normal = c0 > (64'd1 << 30) - 1;
            refl = 1'b0;
            s1 = (n1 != 0) ? num / n1 : 0;
            c1 = root_floor((64'd1 << 60) - s1 * s1);
            if (en) begin
               if (normal) begin
                  d = gap(n1, n0);
                  s = n1 + n0;
                  refl_prob = ((d * d) << 32) / (s * s);
               end else begin
                  refl_prob = oblique_reflectance(c0, s0, c1, s1);
               end
               refl = u <= refl_prob;
            end
            if (refl) begin
               nz = -dz;
               oc = OUTCOME_REFLECT;
            end else begin
               oc = OUTCOME_REFRACT;
               if (!normal) begin
                  nx = bend(dx, n0, n1);
                  ny = bend(dy, n0, n1);
                  nz = (dz > 0) ? longint'(c1) : ((dz < 0) ? -longint'(c1) : 0);
               end
            end
         end
      end
      o.new_x = clamp32(nx);
      o.new_y = clamp32(ny);
      o.new_z = clamp32(nz);
      o.outcome = oc;
      return o;
   endfunction

   // Every accepted item is predicted with the register value of that moment.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            pending_dirs = {pending_dirs, scatter_photon(req_data, enable_copy)};
            items_taken++;
         end
         if (csr_valid && csr_ready) begin
            enable_copy = csr_data;
            csr_writes++;
         end
      end
   end

   // Each strobed result is checked against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_dirs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            want = pending_dirs.pop_front();
            if (rsp_data.new_x !== want.new_x || rsp_data.new_y !== want.new_y ||
                rsp_data.new_z !== want.new_z || rsp_data.outcome !== want.outcome) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected x %h y %h z %h outcome %0d, ",
                            "got x %h y %h z %h outcome %0d"},
                           want.new_x, want.new_y, want.new_z, want.outcome,
                           rsp_data.new_x, rsp_data.new_y, rsp_data.new_z, rsp_data.outcome);
            end
         end
      end
   end

   // Offers one item, with an occasional random gap first, and returns once it is taken.
   task automatic send_item(input req_type it);
      int n;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      start = 1'b1;
      req_data = it;
      n = items_taken;
      do @(negedge clock); while (items_taken == n);
   endtask

   // Waits until every predicted result has arrived and the pipeline is empty.
   task automatic drain;
      start = 1'b0;
      while (pending_dirs.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic write_enable(input bit v);
      int n;
      drain();
      csr_valid = 1'b1;
      csr_data = v;
      n = csr_writes;
      do @(negedge clock); while (csr_writes == n);
      csr_valid = 1'b0;
   endtask

   function automatic req_type photon(input int x, input int y, input int z,
                                      input int n0, input int n1, input int unsigned u);
      req_type r;
      r.dir_x = x;
      r.dir_y = y;
      r.dir_z = z;
      r.index_from = n0[14:0];
      r.index_to = n1[14:0];
      r.rand_u = u;
      return r;
   endfunction

   // Mostly unit vectors in random directions with physical indices; some items carry
   // equal indices, an exactly normal direction, an index drop or entirely random bits.
   function automatic req_type random_photon;
      req_type r;
      real     th, ph;
      int      kind;
      kind = $urandom_range(0, 19);
      th = ($urandom / 4294967296.0) * 3.14159265;
      ph = ($urandom / 4294967296.0) * 6.28318531;
      r = photon($rtoi($sin(th) * $cos(ph) * 1073741824.0),
                 $rtoi($sin(th) * $sin(ph) * 1073741824.0),
                 $rtoi($cos(th) * 1073741824.0),
                 $urandom_range(8192, 32767), $urandom_range(8192, 32767), $urandom);
      if (kind == 0) begin
         r = photon($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (kind == 1) begin
         r.index_to = r.index_from;
      end else if (kind == 2) begin
         r.dir_z = $urandom_range(0, 1) ? 32'sh4000_0000 : -32'sh4000_0000;
         r.dir_x = 0;
         r.dir_y = 0;
      end else if (kind == 3) begin
         r.index_to = 15'($urandom_range(8192, 9000));
         r.index_from = 15'($urandom_range(20000, 32767));
      end
      return r;
   endfunction

   // The extremes of every field and each special case of the arithmetic.
   task automatic test_edge_cases;
      send_item(photon(0, 0, 32'h4000_0000, 8192, 12288, 0));
      send_item(photon(0, 0, -32'sh4000_0000, 12288, 8192, 32'hFFFF_FFFF));
      send_item(photon(0, 0, 32'h3FFF_FFFF, 8192, 32767, 32'h0100_0000));
      send_item(photon(32'h4000_0000, 0, 0, 8192, 12288, 32'h8000_0000));
      send_item(photon(32'h2D41_3CCC, 32'h2D41_3CCC, 1, 10000, 11000, 5));
      send_item(photon(32'h2000_0000, 32'h2000_0000, 32'h2D41_3CCC, 32767, 8192, 0));
      send_item(photon(32'h3000_0000, 0, -32'sh2000_0000, 16384, 8192, 0));
      send_item(photon(32'h1000_0000, 32'h1000_0000, 32'h3000_0000, 16384, 16384, 7));
      send_item(photon(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 8192, 16384, 32'hFFFF_FFFF));
      send_item(photon(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 9000, 0, 1));
      send_item(photon(32'h2000_0000, 0, 32'h3000_0000, 12000, 0, 0));
      send_item(photon(0, 0, 32'h4000_0000, 12000, 0, 32'hFFFF_FFFF));
      send_item(photon(0, 0, 32'h8000_0000, 0, 32767, 0));
      send_item(photon(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1000_0000, 32767, 8192, 0));
      send_item(photon(32'h1234_5678, -32'sh0ABC_DEF0, 32'h3800_0000, 13000, 16000,
                       32'hFFFF_FFFF));
   endtask

   task automatic test_random_photons(input int count);
      repeat (count) send_item(random_photon());
   endtask

   // The sender holds off once, mid stream, until every result has come back.
   task automatic test_held_sender;
      test_random_photons(100);
      start = 1'b0;
      while (pending_dirs.size() != 0) @(negedge clock);
      test_random_photons(100);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = 1'b0;
      enable_copy = 1'b1;
      gaps_on = 1'b1;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      test_edge_cases();
      write_enable(1'b0);
      test_edge_cases();
      test_random_photons(300);
      write_enable(1'b1);
      test_random_photons(400);
      test_held_sender();
      write_enable(1'b0);
      test_random_photons(150);
      write_enable(1'b1);
      // The last part of the run streams without gaps.
      gaps_on = 1'b0;
      test_random_photons(470);
      drain();

      if (mismatches == 0 && pending_dirs.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin
      #2400000;
      $display("tb: errors");
      $finish;
   end

endmodule

[files.f]
design/fik_pkg.sv
design/fik_sqrt_pipe.sv
design/fik_div_pipe.sv
design/fresnel_interface_kernel_unit.sv
tb/sv/tb.sv
